/* sv/drt_pkg.sv */
// ----------------------------------------------------------------------------
// drt_pkg
// Shared types and constants of the disjoint range tracker.
// ----------------------------------------------------------------------------
package drt_pkg;

    localparam int MaxRanges = 16;
    localparam int ValueBits = 16;

    localparam logic       ActAdd  = 1'b0;
    localparam logic       ActList = 1'b1;

    localparam logic [1:0] StOk     = 2'd0;
    localparam logic [1:0] StFull   = 2'd1;
    localparam logic [1:0] StEmpty  = 2'd2;
    localparam logic [1:0] StListed = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic load;      // capture input beat, run compare
        logic apply;     // perform table update
        logic list_clr;  // reset list index
        logic list_inc;  // advance list index
        logic out_add;   // load add result into output register
        logic out_list;  // load listed range into output register
        logic out_empty; // load empty status into output register
        logic out_take;  // output beat consumed
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic is_list;
        logic empty;
        logic list_last;
        logic out_full;
    } t_sts;

endpackage

/* sv/drt_datapath.sv */
// ----------------------------------------------------------------------------
// drt_datapath
// Range table with parallel compare, shift/merge update and list readout.
// ----------------------------------------------------------------------------
module drt_datapath #(
    parameter int MAX_RANGES = drt_pkg::MaxRanges,
    parameter int VALUE_BITS = drt_pkg::ValueBits
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_action,
    input  logic [VALUE_BITS-1:0] i_value,
    input  drt_pkg::t_cmd         i_cmd,
    output drt_pkg::t_sts         o_sts,
    output logic [VALUE_BITS-1:0] o_range_start,
    output logic [VALUE_BITS-1:0] o_range_end,
    output logic                  o_is_last,
    output logic [1:0]            o_status
);
    localparam int IW = $clog2(MAX_RANGES);
    localparam int CW = $clog2(MAX_RANGES + 1);

    logic [VALUE_BITS-1:0] r_starts [MAX_RANGES];
    logic [VALUE_BITS-1:0] r_ends   [MAX_RANGES];
    logic [CW-1:0]         r_count;
    logic                  r_act;
    logic [VALUE_BITS-1:0] r_val;
    logic [CW-1:0]         r_pos;
    logic                  r_cont, r_left, r_right;
    logic [IW-1:0]         r_idx;
    logic                  r_ovld;
    logic [VALUE_BITS-1:0] r_os, r_oe;
    logic                  r_olast;
    logic [1:0]            r_ost;

    // parallel compare against all cells
    logic [MAX_RANGES-1:0] le;
    logic [CW-1:0]         n_pos;
    logic                  n_cont, n_left, n_right;
    logic [VALUE_BITS:0]   v_ext;
    always_comb begin
        v_ext = {1'b0, r_val};
        for (int i = 0; i < MAX_RANGES; i++)
            le[i] = (CW'(i) < r_count) && (r_starts[i] <= r_val);
        n_pos = CW'($countones(le));
        n_cont = 1'b0; n_left = 1'b0; n_right = 1'b0;
        if (n_pos != '0) begin
            n_cont = r_ends[IW'(n_pos - 1'b1)] >= r_val;
            n_left = ({1'b0, r_ends[IW'(n_pos - 1'b1)]} + 1'b1) == v_ext;
        end
        if (n_pos < r_count)
            n_right = {1'b0, r_starts[IW'(n_pos)]} == v_ext + 1'b1;
    end

    logic grow, merge, full;
    assign merge = r_left && r_right;
    assign full  = r_count == CW'(MAX_RANGES);
    assign grow  = !r_cont && !r_left && !r_right && !full;

    // compare stage and update stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            if (i_cmd.apply && !r_cont) begin
                if (merge) r_count <= r_count - 1'b1;
                else if (grow) r_count <= r_count + 1'b1;
            end
        end
        if (i_cmd.load) begin
            r_act <= i_action;
            r_val <= i_value;
        end
        r_pos <= n_pos; r_cont <= n_cont; r_left <= n_left; r_right <= n_right;
        if (i_cmd.apply && !r_cont) begin
            for (int i = 0; i < MAX_RANGES; i++) begin
                if (merge) begin
                    if (CW'(i) + 1'b1 == r_pos) r_ends[i] <= r_ends[IW'(r_pos)];
                    else if (CW'(i) >= r_pos && i + 1 < MAX_RANGES) begin
                        r_starts[i] <= r_starts[(i + 1) % MAX_RANGES];
                        r_ends[i]   <= r_ends[(i + 1) % MAX_RANGES];
                    end
                end else if (r_left) begin
                    if (CW'(i) + 1'b1 == r_pos) r_ends[i] <= r_val;
                end else if (r_right) begin
                    if (CW'(i) == r_pos) r_starts[i] <= r_val;
                end else if (grow) begin
                    if (CW'(i) == r_pos) begin
                        r_starts[i] <= r_val;
                        r_ends[i]   <= r_val;
                    end else if (CW'(i) > r_pos && i > 0) begin
                        r_starts[i] <= r_starts[(i + MAX_RANGES - 1) % MAX_RANGES];
                        r_ends[i]   <= r_ends[(i + MAX_RANGES - 1) % MAX_RANGES];
                    end
                end
            end
        end
    end

    // list index and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
            r_idx  <= '0;
        end else begin
            if (i_cmd.list_clr) r_idx <= '0;
            else if (i_cmd.list_inc) r_idx <= r_idx + 1'b1;
            if (i_cmd.out_add || i_cmd.out_list || i_cmd.out_empty) r_ovld <= 1'b1;
            else if (i_cmd.out_take) r_ovld <= 1'b0;
        end
        if (i_cmd.out_add) begin
            r_os <= '0; r_oe <= '0; r_olast <= 1'b1;
            r_ost <= (!r_cont && !r_left && !r_right && full) ? drt_pkg::StFull
                                                               : drt_pkg::StOk;
        end else if (i_cmd.out_empty) begin
            r_os <= '0; r_oe <= '0; r_olast <= 1'b1; r_ost <= drt_pkg::StEmpty;
        end else if (i_cmd.out_list) begin
            r_os    <= r_starts[r_idx];
            r_oe    <= r_ends[r_idx];
            r_olast <= (CW'(r_idx) + 1'b1) == r_count;
            r_ost   <= drt_pkg::StListed;
        end
    end

    assign o_sts.is_list   = r_act == drt_pkg::ActList;
    assign o_sts.empty     = r_count == '0;
    assign o_sts.list_last = (CW'(r_idx) + 1'b1) == r_count;
    assign o_sts.out_full  = r_ovld;
    assign o_range_start = r_os;
    assign o_range_end   = r_oe;
    assign o_is_last     = r_olast;
    assign o_status      = r_ost;
endmodule

/* sv/drt_ctrl.sv */
// ----------------------------------------------------------------------------
// drt_ctrl
// Sequencer: accept, compare, update or list, hand results to output register.
// ----------------------------------------------------------------------------
module drt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_stall,
    input  drt_pkg::t_sts i_sts,
    output logic          o_stall,
    output logic          o_valid,
    output drt_pkg::t_cmd o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_UPD  = 4'b0100,
        S_LIST = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   take;

    assign take    = i_sts.out_full && !i_stall;
    assign o_valid = i_sts.out_full;
    assign o_stall = r_state != S_IDLE;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.out_take = take;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.list_clr = 1'b1;
                n_state = i_sts.is_list ? S_LIST : S_UPD;
            end
            S_UPD: begin
                if (!i_sts.out_full || take) begin
                    o_cmd.apply   = 1'b1;
                    o_cmd.out_add = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_LIST: begin
                if (!i_sts.out_full || take) begin
                    if (i_sts.empty) begin
                        o_cmd.out_empty = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.out_list = 1'b1;
                        o_cmd.list_inc = 1'b1;
                        if (i_sts.list_last) n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

/* sv/disjoint_range_tracker.sv */
// ----------------------------------------------------------------------------
// disjoint_range_tracker
// Sorted table of disjoint inclusive ranges with add and list commands.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall) carries action and value. Output channel
// (o_valid / i_stall) carries range_start, range_end, is_last and status.
// An add beat is taken in idle, compared against every table cell in
// parallel in the next cycle, then the shift or merge is applied while the
// result goes into the output register once that register is free.
// A list beat gives one result beat per stored range, read from the table
// in order, or a single empty-status beat when the table is empty.
// The next input beat is taken while the last result still waits in the
// output register. When the receiver stalls, the result is held and the
// sequencer waits before loading the next one.
// Reset (synchronous, active low) empties the table and drops any result.
// ----------------------------------------------------------------------------
module disjoint_range_tracker #(
    parameter int MAX_RANGES = drt_pkg::MaxRanges,
    parameter int VALUE_BITS = drt_pkg::ValueBits
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_action,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [VALUE_BITS-1:0] o_range_start,
    output logic [VALUE_BITS-1:0] o_range_end,
    output logic                  o_is_last,
    output logic [1:0]            o_status
);
    drt_pkg::t_cmd cmd;
    drt_pkg::t_sts sts;

    // sequencer
    drt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall(i_stall),
        .i_sts(sts), .o_stall(o_stall), .o_valid(o_valid), .o_cmd(cmd)
    );

    // range table
    drt_datapath #(.MAX_RANGES(MAX_RANGES), .VALUE_BITS(VALUE_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_action(i_action), .i_value(i_value),
        .i_cmd(cmd), .o_sts(sts), .o_range_start(o_range_start),
        .o_range_end(o_range_end), .o_is_last(o_is_last), .o_status(o_status)
    );
endmodule
